@@ hdl/fbpb_pkg.sv @@
package fbpb_pkg;

   localparam int COORD_BITS = 12;
   localparam int ADDR_BITS = 24;
   localparam int MAX_BPP = 4;
   localparam int CHAN_MAX = 8;
   localparam int WORD_BITS = 8 * MAX_BPP;
   localparam int BPP_BITS = 3;
   localparam int ALIGN_BITS = 9;
   localparam int XOFF_BITS = COORD_BITS + 1;
   localparam int POS_BITS = COORD_BITS + 3;
   localparam int XTERM_BITS = POS_BITS + BPP_BITS;
   localparam int CSR_DATA_BITS = 30;
   localparam int CSR_INDEX_BITS = 3;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [WORD_BITS-1:0] word_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_FB_RESOLUTION   = 3'd0,
      REG_LINE_STRIDE     = 3'd1,
      REG_BYTES_PER_PIXEL = 3'd2,
      REG_PAN_OFFSET      = 3'd3,
      REG_COLOR_FORMAT    = 3'd4,
      REG_ALIGN_FRACTION  = 3'd5,
      REG_REGION_SIZE     = 3'd6
   } csr_index_type;

   function automatic word_type pack_chan(input logic [7:0] value, input logic [4:0] len,
                                          input logic [4:0] off);
      logic [3:0] len_sat;
      word_type   shifted;
      len_sat = (len > 5'(CHAN_MAX)) ? 4'(CHAN_MAX) : len[3:0];
      shifted = word_type'(value) >> (4'(CHAN_MAX) - len_sat);
      return shifted << off;
   endfunction

endpackage

@@ hdl/framebuffer_pixel_blitter_unit.sv @@
// Blits RGB888 source pixels, arriving one per request in row-major order, into
// a packed framebuffer as byte writes. A request can be taken in every cycle
// unless the pipeline stalls; a pixel outside the clipped region or with zero
// bytes_per_pixel is dropped, and a kept pixel produces bytes_per_pixel write
// responses, capped at 4, least significant byte first, one per cycle on the
// single-byte response port while rsp_tready is high, which sets the rate. A
// pixel's first byte follows the s1, s2 and output registers. Registers must be
// written only while the block is idle; the block has no check for this.
module framebuffer_pixel_blitter_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [23:0]                      req_tdata,  // red_in, green_in, blue_in
   input  logic                             req_tuser,  // first_of_image
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [31:0]                      rsp_tdata,  // byte_address, byte_data
   output logic                             rsp_tlast,
   input  logic                             csr_we,
   input  logic [fbpb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [fbpb_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import fbpb_pkg::*;

   logic [23:0]          fb_resolution_ff;
   logic [15:0]          line_stride_ff;
   logic [BPP_BITS-1:0]  bytes_per_pixel_ff;
   logic [23:0]          pan_offset_ff;
   logic [29:0]          color_format_ff;
   logic [17:0]          align_fraction_ff;
   logic [23:0]          region_size_ff;

   coord_type            column_ff, column_in;
   coord_type            row_ff, row_in;

   logic [XOFF_BITS-1:0] xoff_ff, xoff_in;
   logic [XOFF_BITS-1:0] yoff_ff, yoff_in;

   logic                 s1_valid_ff;
   coord_type            s1_col_ff, s1_row_ff;
   logic [23:0]          s1_rgb_ff;
   logic [BPP_BITS-1:0]  s1_nb_ff;

   logic                 s2_valid_ff;
   logic [XTERM_BITS-1:0] s2_xterm_ff, s2_xterm_in;
   addr_type             s2_yterm_ff, s2_yterm_in;
   word_type             s2_word_ff, s2_word_in;
   logic [BPP_BITS-1:0]  s2_nb_ff;

   logic                 out_valid_ff;
   addr_type             out_addr_ff;
   word_type             out_word_ff;
   logic [BPP_BITS-1:0]  out_left_ff;

   coord_type            xres, yres, reg_w, reg_h, clip_w, clip_h;
   coord_type            cur_col, cur_row;
   logic [COORD_BITS:0]  col_next;
   logic [BPP_BITS-1:0]  nb_sat;
   logic                 keep;
   logic                 req_take, rsp_take;
   logic                 out_free, s2_free, s1_free;
   logic [POS_BITS-1:0]  xpos, ypos;
   logic [COORD_BITS+ALIGN_BITS-1:0] xprod, yprod;

   assign xres   = fb_resolution_ff[COORD_BITS-1:0];
   assign yres   = fb_resolution_ff[2*COORD_BITS-1:COORD_BITS];
   assign reg_w  = region_size_ff[COORD_BITS-1:0];
   assign reg_h  = region_size_ff[2*COORD_BITS-1:COORD_BITS];
   assign clip_w = (reg_w < xres) ? reg_w : xres;
   assign clip_h = (reg_h < yres) ? reg_h : yres;
   assign nb_sat = (bytes_per_pixel_ff > BPP_BITS'(MAX_BPP)) ? BPP_BITS'(MAX_BPP)
                                                             : bytes_per_pixel_ff;

   assign xprod   = (COORD_BITS+ALIGN_BITS)'(xres - clip_w) *
                    (COORD_BITS+ALIGN_BITS)'(align_fraction_ff[ALIGN_BITS-1:0]);
   assign yprod   = (COORD_BITS+ALIGN_BITS)'(yres - clip_h) *
                    (COORD_BITS+ALIGN_BITS)'(align_fraction_ff[2*ALIGN_BITS-1:ALIGN_BITS]);
   assign xoff_in = xprod[COORD_BITS+ALIGN_BITS-1:8];
   assign yoff_in = yprod[COORD_BITS+ALIGN_BITS-1:8];

   assign out_free   = !out_valid_ff || (rsp_tready && out_left_ff == BPP_BITS'(1));
   assign s2_free    = !s2_valid_ff || out_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_tready = s1_free;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_take   = rsp_tvalid && rsp_tready;

   always_comb begin
      cur_col = req_tuser ? '0 : column_ff;
      cur_row = req_tuser ? '0 : row_ff;
      col_next = {1'b0, cur_col} + (COORD_BITS+1)'(1);
      if (col_next >= {1'b0, reg_w}) begin
         column_in = '0;
         row_in    = cur_row + COORD_BITS'(1);
      end else begin
         column_in = col_next[COORD_BITS-1:0];
         row_in    = cur_row;
      end
      keep = (cur_col < clip_w) && (cur_row < clip_h) && (nb_sat != '0);
   end

   always_comb begin
      xpos = POS_BITS'(s1_col_ff) + POS_BITS'(pan_offset_ff[COORD_BITS-1:0]) +
             POS_BITS'(xoff_ff);
      ypos = POS_BITS'(s1_row_ff) + POS_BITS'(pan_offset_ff[2*COORD_BITS-1:COORD_BITS]) +
             POS_BITS'(yoff_ff);
      s2_xterm_in = XTERM_BITS'(xpos) * XTERM_BITS'(s1_nb_ff);
      s2_yterm_in = addr_type'(ypos) * addr_type'(line_stride_ff);
      s2_word_in  = pack_chan(s1_rgb_ff[7:0], color_format_ff[4:0], color_format_ff[9:5]) |
                    pack_chan(s1_rgb_ff[15:8], color_format_ff[14:10],
                              color_format_ff[19:15]) |
                    pack_chan(s1_rgb_ff[23:16], color_format_ff[24:20],
                              color_format_ff[29:25]);
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_word_ff[7:0], out_addr_ff[23:0]};
   assign rsp_tlast  = out_left_ff == BPP_BITS'(1);

   always_ff @(posedge clock) begin
      xoff_ff <= xoff_in;
      yoff_ff <= yoff_in;
      if (reset) begin
         fb_resolution_ff   <= 24'd1966720;
         line_stride_ff     <= 16'd2560;
         bytes_per_pixel_ff <= BPP_BITS'(4);
         pan_offset_ff      <= '0;
         color_format_ff    <= 30'd8659464;
         align_fraction_ff  <= 18'd65664;
         region_size_ff     <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_FB_RESOLUTION:   fb_resolution_ff   <= csr_data[23:0];
            REG_LINE_STRIDE:     line_stride_ff     <= csr_data[15:0];
            REG_BYTES_PER_PIXEL: bytes_per_pixel_ff <= csr_data[BPP_BITS-1:0];
            REG_PAN_OFFSET:      pan_offset_ff      <= csr_data[23:0];
            REG_COLOR_FORMAT:    color_format_ff    <= csr_data[29:0];
            REG_ALIGN_FRACTION:  align_fraction_ff  <= csr_data[17:0];
            REG_REGION_SIZE:     region_size_ff     <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         out_left_ff  <= '0;
      end else begin
         if (req_take) begin
            column_ff <= column_in;
            row_ff    <= row_in;
         end

         if (s1_free) begin
            s1_valid_ff <= req_take && keep;
         end
         if (req_take) begin
            s1_col_ff <= cur_col;
            s1_row_ff <= cur_row;
            s1_rgb_ff <= req_tdata;
            s1_nb_ff  <= nb_sat;
         end

         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
            s2_xterm_ff <= s2_xterm_in;
            s2_yterm_ff <= s2_yterm_in;
            s2_word_ff  <= s2_word_in;
            s2_nb_ff    <= s1_nb_ff;
         end

         if (out_free) begin
            out_valid_ff <= s2_valid_ff;
            out_addr_ff  <= addr_type'(s2_xterm_ff) + s2_yterm_ff;
            out_word_ff  <= s2_word_ff;
            out_left_ff  <= s2_nb_ff;
         end else if (rsp_take) begin
            out_addr_ff <= out_addr_ff + addr_type'(1);
            out_word_ff <= out_word_ff >> 8;
            out_left_ff <= out_left_ff - BPP_BITS'(1);
         end
      end
   end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import fbpb_pkg::*;

   localparam int SETTLE_CYCLES = 12;

   typedef struct {
      logic [23:0] resolution;
      logic [15:0] stride;
      logic [2:0]  bpp;
      logic [23:0] pan;
      logic [29:0] format;
      logic [17:0] align;
      logic [23:0] region;
   } blit_settings;

   typedef struct packed {
      logic [23:0] addr;
      logic [7:0]  data;
      logic        last;
   } fb_write;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [23:0]               req_tdata = '0;
   logic                      req_tuser = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [31:0]               rsp_tdata;
   logic                      rsp_tlast;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   blit_settings live_regs;
   logic [11:0]  column_pos;
   logic [11:0]  row_pos;
   fb_write      expected_writes[$];
   int           mismatch_count = 0;
   bit           idling = 1'b1;
   int           ready_hold = 0;

   framebuffer_pixel_blitter_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [29:0] format_word(input int rl, ro, gl, go, bl, bo);
      return {5'(bo), 5'(bl), 5'(go), 5'(gl), 5'(ro), 5'(rl)};
   endfunction

   function automatic logic [63:0] channel_bits(input logic [7:0] value, input logic [4:0] len,
                                                input logic [4:0] off);
      logic [4:0] kept;
      kept = (len > CHAN_MAX) ? 5'(CHAN_MAX) : len;
      if (kept == 0)
         return 64'd0;
      return (64'(value) >> (CHAN_MAX - kept)) << off;
   endfunction

   // Advances the position counters and queues the byte writes of one pixel.
   function automatic void predict_pixel_writes(input logic [7:0] red, green, blue,
                                                input logic first);
      logic [63:0] xres, yres, rw, rh, wclip, hclip, col, row, nb, xoff, yoff, pix, addr;
      fb_write     wr;
      int          k;
      xres = live_regs.resolution[11:0];
      yres = live_regs.resolution[23:12];
      rw = live_regs.region[11:0];
      rh = live_regs.region[23:12];
      wclip = (rw < xres) ? rw : xres;
      hclip = (rh < yres) ? rh : yres;
      if (first) begin
         column_pos = '0;
         row_pos = '0;
      end
      col = column_pos;
      row = row_pos;
      if (col + 64'd1 >= rw) begin
         column_pos = '0;
         row_pos = row_pos + 12'd1;
      end else begin
         column_pos = column_pos + 12'd1;
      end
      if (col >= wclip || row >= hclip)
         return;
      nb = (live_regs.bpp > MAX_BPP) ? 64'(MAX_BPP) : 64'(live_regs.bpp);
      if (nb == 0)
         return;
      xoff = ((xres - wclip) * 64'(live_regs.align[8:0])) >> 8;
      yoff = ((yres - hclip) * 64'(live_regs.align[17:9])) >> 8;
      pix = channel_bits(red, live_regs.format[4:0], live_regs.format[9:5])
          | channel_bits(green, live_regs.format[14:10], live_regs.format[19:15])
          | channel_bits(blue, live_regs.format[24:20], live_regs.format[29:25]);
      addr = (col + 64'(live_regs.pan[11:0]) + xoff) * nb
           + (row + 64'(live_regs.pan[23:12]) + yoff) * 64'(live_regs.stride);
      for (k = 0; k < nb; k++) begin
         wr.addr = 24'(addr + 64'(k));
         wr.data = 8'(pix >> (8 * k));
         wr.last = (k + 1 == nb);
         expected_writes.push_back(wr);
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got, want);
      $display("%0t: %s mismatch, got %h, expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic send_pixel(input logic [7:0] red, green, blue, input logic first);
      bit taken;
      if (idling && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {blue, green, red};
      req_tuser <= first;
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      predict_pixel_writes(red, green, blue, first);
   endtask

   task automatic send_random_pixel(input logic first);
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), first);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_settings(input blit_settings s);
      logic [29:0]   reg_value [7];
      csr_index_type idx;
      reg_value[REG_FB_RESOLUTION] = 30'(s.resolution);
      reg_value[REG_LINE_STRIDE] = 30'(s.stride);
      reg_value[REG_BYTES_PER_PIXEL] = 30'(s.bpp);
      reg_value[REG_PAN_OFFSET] = 30'(s.pan);
      reg_value[REG_COLOR_FORMAT] = s.format;
      reg_value[REG_ALIGN_FRACTION] = 30'(s.align);
      reg_value[REG_REGION_SIZE] = 30'(s.region);
      wait_drained();
      idx = idx.first();
      repeat (idx.num()) begin
         csr_we <= 1'b1;
         csr_index <= idx;
         csr_data <= reg_value[idx];
         @(posedge clock);
         idx = idx.next();
      end
      csr_we <= 1'b0;
      live_regs = s;
   endtask

   function automatic blit_settings random_settings();
      blit_settings s;
      logic [11:0]  xres, yres, rw, rh;
      xres = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 16));
      yres = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 16));
      rw = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 12));
      rh = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 8));
      s.resolution = {yres, xres};
      s.region = {rh, rw};
      s.stride = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                             : 16'($urandom_range(1, 64));
      s.bpp = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
      s.pan = ($urandom_range(0, 2) == 0) ? 24'($urandom)
                                          : {12'($urandom_range(0, 8)), 12'($urandom_range(0, 8))};
      if ($urandom_range(0, 1) == 0)
         s.format = 30'($urandom);
      else
         s.format = format_word($urandom_range(1, 8), $urandom_range(0, 24),
                                $urandom_range(1, 8), $urandom_range(0, 24),
                                $urandom_range(1, 8), $urandom_range(0, 24));
      s.align = ($urandom_range(0, 1) == 0) ? 18'($urandom)
                                            : {9'($urandom_range(0, 256)),
                                               9'($urandom_range(0, 256))};
      return s;
   endfunction

   task automatic test_reset_values();
      send_random_pixel(1'b1);
      send_random_pixel(1'b0);
   endtask

   task automatic test_pixel_packing();
      blit_settings s;
      s.resolution = 24'h003004;
      s.stride = 16'd16;
      s.bpp = 3'd4;
      s.pan = 24'h0;
      s.format = format_word(8, 0, 8, 8, 8, 16);
      s.align = 18'h0;
      s.region = 24'h002002;
      load_settings(s);
      send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      send_pixel(8'h80, 8'h01, 8'h7F, 1'b0);
      send_pixel(8'h55, 8'hAA, 8'h33, 1'b0);
      send_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
   endtask

   task automatic test_byte_count();
      blit_settings s;
      s.resolution = 24'h001001;
      s.stride = 16'd4;
      s.bpp = 3'd0;
      s.pan = 24'h0;
      s.format = format_word(8, 0, 8, 8, 8, 16);
      s.align = 18'h0;
      s.region = 24'h001001;
      load_settings(s);
      send_random_pixel(1'b1);
      s.bpp = 3'd7;
      s.format = format_word(31, 31, 0, 3, 5, 27);
      load_settings(s);
      send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
      s.resolution = 24'h0;
      s.bpp = 3'd2;
      load_settings(s);
      send_random_pixel(1'b1);
   endtask

   task automatic test_clip_and_place();
      blit_settings s;
      s.resolution = 24'h003003;
      s.stride = 16'hFFFF;
      s.bpp = 3'd3;
      s.pan = 24'hFFFFFF;
      s.format = format_word(5, 11, 6, 5, 5, 0);
      s.align = 18'h3FFFF;
      s.region = 24'h004002;
      load_settings(s);
      for (int i = 0; i < 9; i++)
         send_random_pixel(i == 0);
      send_random_pixel(1'b1);
   endtask

   task automatic test_random_images(input int pixel_budget);
      blit_settings s;
      int           sent;
      int           count;
      bit           broken;
      sent = 0;
      while (sent < pixel_budget) begin
         s = random_settings();
         load_settings(s);
         count = int'(s.region[11:0]) * int'(s.region[23:12]);
         if (count == 0 || count > 40)
            count = $urandom_range(1, 40);
         count += $urandom_range(0, 3);
         broken = ($urandom_range(0, 7) == 0);
         for (int i = 0; i < count; i++) begin
            if (broken)
               send_random_pixel($urandom_range(0, 5) == 0);
            else
               send_random_pixel(i == 0);
         end
         sent += count;
      end
   endtask

   task automatic test_drain_pause();
      blit_settings s;
      s.resolution = 24'h008008;
      s.stride = 16'd40;
      s.bpp = 3'd4;
      s.pan = 24'h001002;
      s.format = format_word(8, 0, 8, 8, 8, 16);
      s.align = 18'h0;
      s.region = 24'h004004;
      load_settings(s);
      for (int i = 0; i < 8; i++)
         send_random_pixel(i == 0);
      wait_drained();
      for (int i = 0; i < 8; i++)
         send_random_pixel(1'b0);
   endtask

   task automatic test_back_to_back();
      idling = 1'b0;
      test_random_images(55);
   endtask

   always @(posedge clock) begin
      if (reset || !idling) begin
         rsp_tready <= 1'b1;
         ready_hold <= 0;
      end else if (ready_hold > 0) begin
         rsp_tready <= 1'b0;
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_tready <= 1'b0;
         ready_hold <= $urandom_range(0, 18);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Handshake signals only change at rising edges, so the falling edge shows
   // what the next rising edge will accept.
   always @(negedge clock) begin
      fb_write want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_writes.size() == 0) begin
            report_mismatch("unexpected write", rsp_tdata, 32'h0);
         end else begin
            want = expected_writes.pop_front();
            if (rsp_tdata[23:0] !== want.addr)
               report_mismatch("byte_address", 32'(rsp_tdata[23:0]), 32'(want.addr));
            if (rsp_tdata[31:24] !== want.data)
               report_mismatch("byte_data", 32'(rsp_tdata[31:24]), 32'(want.data));
            if (rsp_tlast !== want.last)
               report_mismatch("last_of_pixel", 32'(rsp_tlast), 32'(want.last));
         end
      end
   end

   initial begin
      live_regs.resolution = 24'd1966720;
      live_regs.stride = 16'd2560;
      live_regs.bpp = 3'd4;
      live_regs.pan = 24'd0;
      live_regs.format = 30'd8659464;
      live_regs.align = 18'd65664;
      live_regs.region = 24'd0;
      column_pos = '0;
      row_pos = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_pixel_packing();
      test_byte_count();
      test_clip_and_place();
      test_random_images(280);
      test_drain_pause();
      test_back_to_back();
      wait_drained();
      if (mismatch_count == 0 && expected_writes.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #5000000;
      $display("Verification failed");
      $finish;
   end

endmodule
